// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
else $error("same-cycle check failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
else $error("next-cycle check failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== src/bhim_pkg.sv =====
package bhim_pkg;

	localparam int MAX_ROWS_DEF      = 256;
	localparam int MAX_COLS_DEF      = 256;
	localparam int MAX_SURROUNDS_DEF = 128;
	localparam int PASS_LIMIT_DEF    = 65535;

	localparam logic [1:0] REQ_LOAD  = 2'd0;
	localparam logic [1:0] REQ_WRITE = 2'd1;
	localparam logic [1:0] REQ_RUN   = 2'd2;
	localparam logic [1:0] REQ_READ  = 2'd3;

	localparam logic [2:0] REG_ROWS   = 3'd0;
	localparam logic [2:0] REG_COLS   = 3'd1;
	localparam logic [2:0] REG_ITER   = 3'd2;
	localparam logic [2:0] REG_SUBF   = 3'd3;
	localparam logic [2:0] REG_MODE   = 3'd4;
	localparam logic [2:0] REG_LOGIC  = 3'd5;
	localparam logic [2:0] REG_SCOUNT = 3'd6;

	localparam int MT_DEPTH = 512;
	localparam logic [7:0] PIXEL_ONE = 8'd255;

	typedef logic [8:0] nb_t;

	localparam nb_t MODE_MASK [4] = '{9'h0AA, 9'h1AB, 9'h0EE, 9'h1EF};

	typedef struct packed {
		logic       start;
		logic [7:0] nsur;
		nb_t        mask;
	} build_req_t;

endpackage

// ===== src/bhim_match.sv =====
`include "assert_macros.svh"

module bhim_match #(
	parameter int MAX_SURROUNDS = bhim_pkg::MAX_SURROUNDS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  bhim_pkg::build_req_t build,
	input  logic                sur_we,
	input  logic [6:0]          sur_idx,
	input  bhim_pkg::nb_t       sur_pat,
	input  logic                look_re,
	input  bhim_pkg::nb_t       look_nb,
	output logic                look_hit,
	output logic                busy
);

	localparam int SIW = (MAX_SURROUNDS > 1) ? $clog2(MAX_SURROUNDS) : 1;

	typedef enum logic [1:0] {M_IDLE, M_CLR, M_FILL} mstate_t;

	mstate_t       st_q;
	logic [8:0]    cnt_q;
	logic [8:0]    i_q;
	logic [7:0]    nsur_q;
	bhim_pkg::nb_t mask_q;
	logic          fv_s1;
	bhim_pkg::nb_t sur_rd_q;
	logic          hit_q;

	bhim_pkg::nb_t sur_mem [MAX_SURROUNDS];
	logic          mt_mem [bhim_pkg::MT_DEPTH];

	logic          sur_re;
	logic          mt_we;
	logic [8:0]    mt_wa;
	logic          mt_wd;

	assign sur_re   = (st_q == M_FILL) && (i_q < 9'(nsur_q));
	assign busy     = (st_q != M_IDLE) || fv_s1;
	assign look_hit = hit_q;

	always_comb begin
		mt_we = 1'b0;
		mt_wa = cnt_q;
		mt_wd = 1'b0;
		if (st_q == M_CLR) begin
			mt_we = 1'b1;
		end else if (fv_s1) begin
			mt_we = 1'b1;
			mt_wa = sur_rd_q & mask_q;
			mt_wd = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= M_IDLE;
			cnt_q  <= '0;
			i_q    <= '0;
			nsur_q <= '0;
			mask_q <= '0;
			fv_s1  <= 1'b0;
		end else begin
			fv_s1 <= sur_re;
			case (st_q)
				M_IDLE: begin
					if (build.start) begin
						nsur_q <= build.nsur;
						mask_q <= build.mask;
						cnt_q  <= '0;
						st_q   <= M_CLR;
					end
				end
				M_CLR: begin
					cnt_q <= cnt_q + 9'd1;
					if (cnt_q == 9'(bhim_pkg::MT_DEPTH - 1)) begin
						i_q  <= '0;
						st_q <= M_FILL;
					end
				end
				M_FILL: begin
					if (sur_re) begin
						i_q <= i_q + 9'd1;
					end else begin
						st_q <= M_IDLE;
					end
				end
				default: st_q <= M_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (sur_we) begin
			sur_mem[SIW'(sur_idx)] <= sur_pat;
		end
		if (sur_re) begin
			sur_rd_q <= sur_mem[SIW'(i_q)];
		end
		if (mt_we) begin
			mt_mem[mt_wa] <= mt_wd;
		end
		if (look_re) begin
			hit_q <= mt_mem[look_nb & mask_q];
		end
	end

	`ASSERT_IMPL(a_start_idle, clk, arst_n, build.start, !busy)
	`ASSERT_NEXT(a_start_busy, clk, arst_n, build.start, busy)
	`ASSERT_IMPL(a_look_ready, clk, arst_n, look_re, !busy)

endmodule

// ===== src/binary_hex_iterative_modification_unit.sv =====
// Channel   Handshake                   Payload
// input     in_valid / in_ready         req_type, row, col, pixel_in, surround_index,
//                                       surround_pattern
// output    out_valid / out_ready       pixel_out, pass_count, stopped_stable, limit_hit
// config    psel, penable, pwrite       paddr, pwdata, prdata, pready
// Load, write and read requests stream at one per cycle while the output register is empty
// or being taken; a read result passes through the image read register and then the
// output register. A run first clears and fills the 512-entry match memory, then each pass
// over an image of at least 3x3 copies rows*cols pixels into the snapshot one per cycle and
// reads the nine pixels of each processed window through the single snapshot read port.
// Reset leaves the image and the surround table unwritten; registers take their defaults.
// While the output register holds an untaken result, one more item is accepted and the
// item after it waits; a run holds the input off until its result is in the output register.
`include "assert_macros.svh"

module binary_hex_iterative_modification_unit #(
	parameter int MAX_ROWS      = bhim_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS      = bhim_pkg::MAX_COLS_DEF,
	parameter int MAX_SURROUNDS = bhim_pkg::MAX_SURROUNDS_DEF,
	parameter int PASS_LIMIT    = bhim_pkg::PASS_LIMIT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  req_type,
	input  logic [7:0]  row,
	input  logic [7:0]  col,
	input  logic [7:0]  pixel_in,
	input  logic [6:0]  surround_index,
	input  logic [8:0]  surround_pattern,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  pixel_out,
	output logic [15:0] pass_count,
	output logic        stopped_stable,
	output logic        limit_hit,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int DEPTH = MAX_ROWS * MAX_COLS;
	localparam int AW    = $clog2(DEPTH);
	localparam int PW    = $clog2(PASS_LIMIT + 1);

	typedef enum logic [3:0] {
		ST_IDLE, ST_MATCH, ST_PSTART, ST_COPY, ST_ROW, ST_WRD, ST_WMATCH, ST_WB,
		ST_PEND, ST_DONE
	} state_t;

	function automatic logic [AW-1:0] pix_addr(input logic [9:0] r, input logic [9:0] c);
		pix_addr = AW'(AW'(r) * AW'(MAX_COLS) + AW'(c));
	endfunction

	logic [8:0] rows_cfg_q;
	logic [8:0] cols_cfg_q;
	logic [7:0] iter_cfg_q;
	logic [3:0] subf_cfg_q;
	logic [1:0] mode_cfg_q;
	logic [3:0] logic_cfg_q;
	logic [7:0] scount_cfg_q;

	state_t        st_q;
	logic          item_v_s1;
	logic          item_rd_s1;
	logic          out_v_q;
	logic [7:0]    pix_q;
	logic [15:0]   opc_q;
	logic          ostab_q;
	logic          olim_q;
	logic [15:0]   pc_q;
	logic          stab_q;
	logic          lim_q;
	logic [8:0]    rows_q;
	logic [8:0]    cols_q;
	logic [3:0]    f_q;
	logic [11:0]   total_q;
	logic          iter_nz_q;
	logic [3:0]    phase_q;
	logic [PW-1:0] passes_q;
	logic          changed_q;
	logic [8:0]    cy_q;
	logic [8:0]    cx_q;
	logic [9:0]    y_q;
	logic [9:0]    x_q;
	logic [3:0]    fst_q;
	logic [1:0]    ys_q;
	logic [1:0]    xs_q;
	logic [3:0]    k_q;
	logic          b_q;
	logic          cp_v_s1;
	logic [AW-1:0] cp_a_s1;
	logic          sv_s1;
	logic [3:0]    sk_s1;
	bhim_pkg::nb_t nb_q;

	logic          img_mem  [DEPTH];
	logic          snap_mem [DEPTH];
	logic          img_rd_q;
	logic          snap_rd_q;

	logic          accept;
	logic          adv;
	logic          in_store;
	logic          cfg_wr;
	logic          img_we;
	logic [AW-1:0] img_wa;
	logic          img_wd;
	logic          img_re;
	logic [AW-1:0] img_ra;
	logic          snap_re;
	logic [AW-1:0] snap_ra;
	logic          hit;
	logic          busy;
	logic          new_pix;
	logic [3:0]    fst_n;
	logic [9:0]    x_next;
	logic [3:0]    phase_n;
	logic [PW:0]   passes_n;
	logic          interior;
	bhim_pkg::build_req_t build;

	assign cfg_wr   = psel && penable && pwrite;
	assign pready   = 1'b1;
	assign adv      = !out_v_q || out_ready;
	assign in_ready = (st_q == ST_IDLE) && (!item_v_s1 || adv);
	assign accept   = in_valid && in_ready;
	assign in_store = (32'(row) < MAX_ROWS) && (32'(col) < MAX_COLS);

	assign out_valid      = out_v_q;
	assign pixel_out      = pix_q;
	assign pass_count     = opc_q;
	assign stopped_stable = ostab_q;
	assign limit_hit      = olim_q;

	assign new_pix  = logic_cfg_q[{hit, b_q}];
	assign fst_n    = (fst_q == 4'd0) ? f_q - 4'd1 : fst_q - 4'd1;
	assign x_next   = x_q + 10'(f_q);
	assign phase_n  = (phase_q == f_q - 4'd1) ? 4'd0 : phase_q + 4'd1;
	assign passes_n = (PW + 1)'(passes_q) + (PW + 1)'(1);
	assign interior = (rows_q >= 9'd3) && (cols_q >= 9'd3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_cfg_q   <= 9'd256;
			cols_cfg_q   <= 9'd256;
			iter_cfg_q   <= 8'd1;
			subf_cfg_q   <= 4'd1;
			mode_cfg_q   <= 2'd3;
			logic_cfg_q  <= 4'd0;
			scount_cfg_q <= 8'd0;
		end else if (cfg_wr) begin
			case (paddr[4:2])
				bhim_pkg::REG_ROWS:   rows_cfg_q   <= pwdata[8:0];
				bhim_pkg::REG_COLS:   cols_cfg_q   <= pwdata[8:0];
				bhim_pkg::REG_ITER:   iter_cfg_q   <= pwdata[7:0];
				bhim_pkg::REG_SUBF:   subf_cfg_q   <= pwdata[3:0];
				bhim_pkg::REG_MODE:   mode_cfg_q   <= pwdata[1:0];
				bhim_pkg::REG_LOGIC:  logic_cfg_q  <= pwdata[3:0];
				bhim_pkg::REG_SCOUNT: scount_cfg_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			bhim_pkg::REG_ROWS:   prdata = 32'(rows_cfg_q);
			bhim_pkg::REG_COLS:   prdata = 32'(cols_cfg_q);
			bhim_pkg::REG_ITER:   prdata = 32'(iter_cfg_q);
			bhim_pkg::REG_SUBF:   prdata = 32'(subf_cfg_q);
			bhim_pkg::REG_MODE:   prdata = 32'(mode_cfg_q);
			bhim_pkg::REG_LOGIC:  prdata = 32'(logic_cfg_q);
			bhim_pkg::REG_SCOUNT: prdata = 32'(scount_cfg_q);
			default:              prdata = 32'd0;
		endcase
	end

	always_comb begin
		build.start = accept && (req_type == bhim_pkg::REQ_RUN);
		build.nsur  = (32'(scount_cfg_q) > MAX_SURROUNDS) ? 8'(MAX_SURROUNDS) : scount_cfg_q;
		build.mask  = bhim_pkg::MODE_MASK[mode_cfg_q];
	end

	bhim_match #(
		.MAX_SURROUNDS(MAX_SURROUNDS)
	) u_match (
		.clk     (clk),
		.arst_n  (arst_n),
		.build   (build),
		.sur_we  (accept && (req_type == bhim_pkg::REQ_LOAD)
		          && (32'(surround_index) < MAX_SURROUNDS)),
		.sur_idx (surround_index),
		.sur_pat (surround_pattern),
		.look_re (st_q == ST_WMATCH),
		.look_nb ({snap_rd_q, nb_q[7:0]}),
		.look_hit(hit),
		.busy    (busy)
	);

	always_comb begin
		img_we  = 1'b0;
		img_wa  = pix_addr(10'(row), 10'(col));
		img_wd  = |pixel_in;
		img_re  = 1'b0;
		img_ra  = pix_addr(10'(row), 10'(col));
		snap_re = 1'b0;
		snap_ra = pix_addr(y_q + 10'(ys_q), x_q + 10'(xs_q));
		case (st_q)
			ST_IDLE: begin
				img_we = accept && (req_type == bhim_pkg::REQ_WRITE) && in_store;
				img_re = accept && (req_type == bhim_pkg::REQ_READ) && in_store;
			end
			ST_COPY: begin
				img_re = 1'b1;
				img_ra = pix_addr(10'(cy_q), 10'(cx_q));
			end
			ST_WRD: begin
				snap_re = 1'b1;
			end
			ST_WB: begin
				img_we = 1'b1;
				img_wa = pix_addr(y_q + 10'd1, x_q + 10'd1);
				img_wd = new_pix;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (img_we) begin
			img_mem[img_wa] <= img_wd;
		end
		if (img_re) begin
			img_rd_q <= img_mem[img_ra];
		end
		if (cp_v_s1) begin
			snap_mem[cp_a_s1] <= img_rd_q;
		end
		if (snap_re) begin
			snap_rd_q <= snap_mem[snap_ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_IDLE;
			item_v_s1  <= 1'b0;
			item_rd_s1 <= 1'b0;
			out_v_q    <= 1'b0;
			pix_q      <= '0;
			opc_q      <= '0;
			ostab_q    <= 1'b0;
			olim_q     <= 1'b0;
			pc_q       <= '0;
			stab_q     <= 1'b0;
			lim_q      <= 1'b0;
			rows_q     <= '0;
			cols_q     <= '0;
			f_q        <= 4'd1;
			total_q    <= '0;
			iter_nz_q  <= 1'b0;
			phase_q    <= '0;
			passes_q   <= '0;
			changed_q  <= 1'b0;
			cy_q       <= '0;
			cx_q       <= '0;
			y_q        <= '0;
			x_q        <= '0;
			fst_q      <= '0;
			ys_q       <= '0;
			xs_q       <= '0;
			k_q        <= '0;
			b_q        <= 1'b0;
			cp_v_s1    <= 1'b0;
			cp_a_s1    <= '0;
			sv_s1      <= 1'b0;
			sk_s1      <= '0;
			nb_q       <= '0;
		end else begin
			cp_v_s1 <= 1'b0;
			sv_s1   <= 1'b0;
			if (sv_s1) begin
				nb_q[sk_s1] <= snap_rd_q;
			end

			if (st_q == ST_DONE) begin
				if (adv) begin
					out_v_q <= 1'b1;
					pix_q   <= '0;
					opc_q   <= pc_q;
					ostab_q <= stab_q;
					olim_q  <= lim_q;
					st_q    <= ST_IDLE;
				end
			end else if (adv) begin
				out_v_q <= item_v_s1;
				pix_q   <= (item_rd_s1 && img_rd_q) ? bhim_pkg::PIXEL_ONE : 8'd0;
				opc_q   <= pc_q;
				ostab_q <= stab_q;
				olim_q  <= lim_q;
			end

			if (accept && (req_type != bhim_pkg::REQ_RUN)) begin
				item_v_s1  <= 1'b1;
				item_rd_s1 <= (req_type == bhim_pkg::REQ_READ) && in_store;
			end else if (adv) begin
				item_v_s1 <= 1'b0;
			end

			case (st_q)
				ST_IDLE: begin
					if (build.start) begin
						rows_q    <= (32'(rows_cfg_q) > MAX_ROWS) ? 9'(MAX_ROWS) : rows_cfg_q;
						cols_q    <= (32'(cols_cfg_q) > MAX_COLS) ? 9'(MAX_COLS) : cols_cfg_q;
						f_q       <= (subf_cfg_q == 4'd0) ? 4'd1 : subf_cfg_q;
						total_q   <= 12'(iter_cfg_q)
						             * 12'((subf_cfg_q == 4'd0) ? 4'd1 : subf_cfg_q);
						iter_nz_q <= (iter_cfg_q != 8'd0);
						phase_q   <= '0;
						passes_q  <= '0;
						st_q      <= ST_MATCH;
					end
				end
				ST_MATCH: begin
					if (!busy) begin
						st_q <= ST_PSTART;
					end
				end
				ST_PSTART: begin
					changed_q <= 1'b0;
					cy_q      <= '0;
					cx_q      <= '0;
					st_q      <= interior ? ST_COPY : ST_PEND;
				end
				ST_COPY: begin
					cp_v_s1 <= 1'b1;
					cp_a_s1 <= img_ra;
					if (cx_q == cols_q - 9'd1) begin
						cx_q <= '0;
						cy_q <= cy_q + 9'd1;
						if (cy_q == rows_q - 9'd1) begin
							y_q   <= '0;
							x_q   <= 10'(phase_q);
							fst_q <= phase_q;
							st_q  <= ST_ROW;
						end
					end else begin
						cx_q <= cx_q + 9'd1;
					end
				end
				ST_ROW: begin
					if (y_q + 10'd2 >= 10'(rows_q)) begin
						st_q <= ST_PEND;
					end else if (x_q + 10'd2 < 10'(cols_q)) begin
						ys_q <= '0;
						xs_q <= '0;
						k_q  <= '0;
						st_q <= ST_WRD;
					end else begin
						y_q   <= y_q + 10'd1;
						fst_q <= fst_n;
						x_q   <= 10'(fst_n);
					end
				end
				ST_WRD: begin
					sv_s1 <= 1'b1;
					sk_s1 <= k_q;
					k_q   <= k_q + 4'd1;
					if (xs_q == 2'd2) begin
						xs_q <= '0;
						ys_q <= ys_q + 2'd1;
					end else begin
						xs_q <= xs_q + 2'd1;
					end
					if (k_q == 4'd8) begin
						st_q <= ST_WMATCH;
					end
				end
				ST_WMATCH: begin
					b_q  <= nb_q[4];
					st_q <= ST_WB;
				end
				ST_WB: begin
					if (new_pix != b_q) begin
						changed_q <= 1'b1;
					end
					if (x_next + 10'd2 < 10'(cols_q)) begin
						x_q  <= x_next;
						ys_q <= '0;
						xs_q <= '0;
						k_q  <= '0;
						st_q <= ST_WRD;
					end else begin
						y_q   <= y_q + 10'd1;
						fst_q <= fst_n;
						x_q   <= 10'(fst_n);
						st_q  <= ST_ROW;
					end
				end
				ST_PEND: begin
					passes_q <= PW'(passes_n);
					phase_q  <= phase_n;
					if ((phase_n == 4'd0) && !changed_q) begin
						stab_q <= 1'b1;
						lim_q  <= 1'b0;
						st_q   <= ST_DONE;
					end else if ((phase_n == 4'd0) && iter_nz_q
					             && (32'(passes_n) >= 32'(total_q))) begin
						stab_q <= 1'b0;
						lim_q  <= 1'b0;
						st_q   <= ST_DONE;
					end else if (32'(passes_n) >= PASS_LIMIT) begin
						stab_q <= 1'b0;
						lim_q  <= 1'b1;
						st_q   <= ST_DONE;
					end else begin
						st_q <= ST_PSTART;
					end
					pc_q <= (32'(passes_n) > 32'd65535) ? 16'hFFFF : 16'(passes_n);
				end
				default: ;
			endcase
		end
	end

	`ASSERT_NEXT(a_run_start, clk, arst_n, build.start, st_q == ST_MATCH)
	`ASSERT_IMPL(a_copy_wr, clk, arst_n, cp_v_s1, st_q == ST_COPY || st_q == ST_ROW)
	`ASSERT_IMPL(a_done_empty, clk, arst_n, st_q == ST_DONE, !item_v_s1)

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] r;
		logic [7:0] c;
		logic [7:0] value;
		logic [6:0] sidx;
		logic [8:0] spat;
	} request_t;

	typedef struct packed {
		logic [7:0]  pixel;
		logic [15:0] passes;
		logic        stable;
		logic        limit;
	} response_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  req_type = bhim_pkg::REQ_LOAD;
	logic [7:0]  row = '0;
	logic [7:0]  col = '0;
	logic [7:0]  pixel_in = '0;
	logic [6:0]  surround_index = '0;
	logic [8:0]  surround_pattern = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  pixel_out;
	logic [15:0] pass_count;
	logic        stopped_stable;
	logic        limit_hit;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	binary_hex_iterative_modification_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.req_type(req_type), .row(row), .col(col), .pixel_in(pixel_in),
		.surround_index(surround_index), .surround_pattern(surround_pattern),
		.out_valid(out_valid), .out_ready(out_ready),
		.pixel_out(pixel_out), .pass_count(pass_count),
		.stopped_stable(stopped_stable), .limit_hit(limit_hit),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Shadow of the block's image, surround table and registers.
	bit          image_px [65536];
	bit          snap_px [65536];
	logic [8:0]  surrounds [128];
	int unsigned r_rows = 256, r_cols = 256, r_iter = 1, r_subf = 1;
	int unsigned r_mode = 3, r_logic = 0, r_scount = 0;
	logic [15:0] last_passes = '0;
	logic        last_stable = 1'b0;
	logic        last_limit = 1'b0;

	request_t    pending_requests [$];
	response_t   expected_responses [$];
	bit          written [65536];
	bit          calm = 1'b0;
	int          gap = 0;
	int          stall = 0;
	int          mismatches = 0;
	int          idle_cycles = 0;
	int          items = 0;

	function automatic void run_passes();
		int unsigned rws, cls, f, nsur, total, passes, changes, fst;
		int unsigned y, x, ys, xs, i, n, ctr;
		bit          hit [512];
		logic [8:0]  mask;
		logic [8:0]  nb;
		bit          a, b, nxt;
		rws = r_rows > 256 ? 256 : r_rows;
		cls = r_cols > 256 ? 256 : r_cols;
		f = r_subf == 0 ? 1 : r_subf;
		nsur = r_scount > 128 ? 128 : r_scount;
		mask = bhim_pkg::MODE_MASK[r_mode];
		total = r_iter * f;
		for (n = 0; n < 512; n++) begin
			hit[n] = 1'b0;
			for (i = 0; i < nsur; i++)
				if (((n[8:0] ^ surrounds[i]) & mask) == 9'd0)
					hit[n] = 1'b1;
		end
		last_stable = 1'b0;
		last_limit = 1'b0;
		passes = 0;
		while (1) begin
			for (y = 0; y < rws; y++)
				for (x = 0; x < cls; x++)
					snap_px[y * 256 + x] = image_px[y * 256 + x];
			changes = 0;
			fst = passes % f;
			if (rws >= 3 && cls >= 3) begin
				for (y = 0; y + 2 < rws; y++) begin
					for (x = fst; x + 2 < cls; x += f) begin
						nb = '0;
						for (ys = 0; ys < 3; ys++)
							for (xs = 0; xs < 3; xs++)
								if (snap_px[(y + ys) * 256 + x + xs])
									nb[ys * 3 + xs] = 1'b1;
						ctr = (y + 1) * 256 + x + 1;
						a = hit[nb];
						b = snap_px[ctr];
						nxt = r_logic[{a, b}];
						image_px[ctr] = nxt;
						if (nxt != b)
							changes++;
					end
					if (f > 1)
						fst = fst == 0 ? f - 1 : fst - 1;
				end
			end
			passes++;
			if (passes % f == 0) begin
				if (changes == 0) begin
					last_stable = 1'b1;
					break;
				end
				if (r_iter != 0 && passes >= total)
					break;
			end
			if (passes >= bhim_pkg::PASS_LIMIT_DEF) begin
				last_limit = 1'b1;
				break;
			end
		end
		last_passes = passes > 65535 ? 16'hFFFF : passes[15:0];
	endfunction

	function automatic response_t predict_response(request_t q);
		response_t rsp;
		rsp.pixel = '0;
		case (q.kind)
			bhim_pkg::REQ_LOAD: surrounds[q.sidx] = q.spat;
			bhim_pkg::REQ_WRITE: image_px[{q.r, q.c}] = q.value != 8'd0;
			bhim_pkg::REQ_RUN: run_passes();
			default: rsp.pixel = image_px[{q.r, q.c}] ? bhim_pkg::PIXEL_ONE : 8'd0;
		endcase
		rsp.passes = last_passes;
		rsp.stable = last_stable;
		rsp.limit = last_limit;
		return rsp;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap <= 0;
		end else begin
			request_t q;
			if (in_valid && in_ready) begin
				q = '{req_type, row, col, pixel_in, surround_index, surround_pattern};
				expected_responses.push_back(predict_response(q));
			end
			if (!in_valid || in_ready) begin
				if (gap > 0) begin
					gap <= gap - 1;
					in_valid <= 1'b0;
				end else if (pending_requests.size() > 0) begin
					q = pending_requests.pop_front();
					req_type <= q.kind;
					row <= q.r;
					col <= q.c;
					pixel_in <= q.value;
					surround_index <= q.sidx;
					surround_pattern <= q.spat;
					in_valid <= 1'b1;
					if (!calm && $urandom_range(0, 19) == 0)
						gap <= $urandom_range(1, 11);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall <= 0;
		end else begin
			response_t got, want;
			if (stall > 0) begin
				stall <= stall - 1;
				out_ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 15) == 0) begin
				stall <= $urandom_range(0, 10);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
			if (out_valid && out_ready) begin
				got = '{pixel_out, pass_count, stopped_stable, limit_hit};
				if (expected_responses.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("transfer with no expected result: %p", got);
				end else begin
					want = expected_responses.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected %p, actual %p", want, got);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= 8000000) begin
			$display("tb: errors");
			$finish;
		end
	end

	task automatic reg_write(input logic [2:0] idx, input int unsigned val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			bhim_pkg::REG_ROWS: r_rows = val & 9'h1FF;
			bhim_pkg::REG_COLS: r_cols = val & 9'h1FF;
			bhim_pkg::REG_ITER: r_iter = val & 8'hFF;
			bhim_pkg::REG_SUBF: r_subf = val & 4'hF;
			bhim_pkg::REG_MODE: r_mode = val & 2'h3;
			bhim_pkg::REG_LOGIC: r_logic = val & 4'hF;
			default: r_scount = val & 8'hFF;
		endcase
	endtask

	task automatic configure(input int unsigned rws, cls, iter, subf, mode, lg, sc);
		reg_write(bhim_pkg::REG_ROWS, rws);
		reg_write(bhim_pkg::REG_COLS, cls);
		reg_write(bhim_pkg::REG_ITER, iter);
		reg_write(bhim_pkg::REG_SUBF, subf);
		reg_write(bhim_pkg::REG_MODE, mode);
		reg_write(bhim_pkg::REG_LOGIC, lg);
		reg_write(bhim_pkg::REG_SCOUNT, sc);
		@(negedge clk);
	endtask

	task automatic drain();
		do @(negedge clk);
		while (pending_requests.size() != 0 || expected_responses.size() != 0 || in_valid);
		repeat (4) @(negedge clk);
	endtask

	function automatic void push_req(input logic [1:0] k, input logic [7:0] r, c, v,
		input logic [6:0] si, input logic [8:0] sp);
		request_t q;
		q = '{k, r, c, v, si, sp};
		if (k == bhim_pkg::REQ_WRITE)
			written[{r, c}] = 1'b1;
		pending_requests.push_back(q);
		items++;
	endfunction

	function automatic void load_pixel(input logic [7:0] r, c);
		logic [7:0] v;
		v = $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(1, 255));
		push_req(bhim_pkg::REQ_WRITE, r, c, v, 7'($urandom), 9'($urandom));
	endfunction

	function automatic void read_some(input int n, input int rws, input int cls);
		int i;
		for (i = 0; i < n; i++)
			push_req(bhim_pkg::REQ_READ, 8'($urandom_range(0, rws - 1)),
				8'($urandom_range(0, cls - 1)), 8'($urandom), 7'($urandom), 9'($urandom));
	endfunction

	function automatic void fill_region(input int rws, input int cls);
		int y, x;
		for (y = 0; y < rws; y++)
			for (x = 0; x < cls; x++)
				if (!written[y * 256 + x])
					load_pixel(8'(y), 8'(x));
	endfunction

	initial begin
		int i, rws, cls, subf, it, lg, rd;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		push_req(bhim_pkg::REQ_LOAD, 8'd0, 8'd0, 8'd0, 7'd0, 9'd0);
		push_req(bhim_pkg::REQ_LOAD, 8'd0, 8'd0, 8'd0, 7'd127, 9'h1FF);
		push_req(bhim_pkg::REQ_LOAD, 8'd0, 8'd0, 8'd0, 7'd1, 9'h155);
		push_req(bhim_pkg::REQ_WRITE, 8'd255, 8'd255, 8'd255, 7'd0, 9'd0);
		push_req(bhim_pkg::REQ_WRITE, 8'd0, 8'd0, 8'd0, 7'd0, 9'd0);
		push_req(bhim_pkg::REQ_WRITE, 8'd128, 8'd200, 8'd1, 7'd0, 9'd0);
		push_req(bhim_pkg::REQ_WRITE, 8'd1, 8'd1, 8'd128, 7'd0, 9'd0);
		push_req(bhim_pkg::REQ_READ, 8'd255, 8'd255, 8'd0, 7'd0, 9'd0);
		push_req(bhim_pkg::REQ_READ, 8'd0, 8'd0, 8'd255, 7'd127, 9'h1FF);
		push_req(bhim_pkg::REQ_READ, 8'd128, 8'd200, 8'd0, 7'd0, 9'd0);
		fill_region(3, 3);
		drain();

		// Zero subfields act as one; two surrounds in use.
		configure(3, 3, 1, 0, 0, 4'b1010, 2);
		push_req(bhim_pkg::REQ_RUN, 8'd0, 8'd0, 8'd0, 7'd0, 9'd0);
		read_some(3, 3, 3);
		drain();

		// A toggling centre never settles, so the run stops at the pass limit.
		configure(3, 3, 0, 1, 1, 4'b0001, 0);
		push_req(bhim_pkg::REQ_RUN, 8'd0, 8'd0, 8'd0, 7'd0, 9'd0);
		push_req(bhim_pkg::REQ_READ, 8'd1, 8'd1, 8'd0, 7'd0, 9'd0);
		drain();

		configure(3, 3, 255, 8, 2, 4'b0110, 0);
		push_req(bhim_pkg::REQ_RUN, 8'd0, 8'd0, 8'd0, 7'd0, 9'd0);
		drain();

		// Sizes above the store and below the window.
		configure(300, 2, 2, 15, 3, 4'b1111, 0);
		push_req(bhim_pkg::REQ_RUN, 8'd0, 8'd0, 8'd0, 7'd0, 9'd0);
		drain();
		configure(2, 511, 1, 1, 3, 4'b0101, 0);
		push_req(bhim_pkg::REQ_RUN, 8'd0, 8'd0, 8'd0, 7'd0, 9'd0);
		drain();

		for (i = 0; i < 128; i++)
			push_req(bhim_pkg::REQ_LOAD, 8'($urandom), 8'($urandom), 8'($urandom), 7'(i),
				9'($urandom));
		drain();
		configure(3, 3, 1, 1, 3, 4'b1100, 200);
		push_req(bhim_pkg::REQ_RUN, 8'd0, 8'd0, 8'd0, 7'd0, 9'd0);
		read_some(2, 3, 3);
		drain();

		while (items < 1150) begin
			if (items > 1000)
				calm = 1'b1;
			rws = $urandom_range(3, 8);
			cls = $urandom_range(3, 10);
			subf = $urandom_range(0, 3) == 0 ? $urandom_range(1, 8) : $urandom_range(1, 2);
			lg = $urandom_range(0, 15);
			if ($urandom_range(0, 4) == 0) begin
				it = 0;
				// Tables that only grow or only shrink the image always settle.
				lg = $urandom_range(0, 1) ? (lg | 4'b1010) : (lg & 4'b1010);
			end else begin
				it = $urandom_range(1, 2);
			end
			configure(rws, cls, it, subf, $urandom_range(0, 3), lg, $urandom_range(0, 130));
			for (i = $urandom_range(0, 4); i > 0; i--)
				push_req(bhim_pkg::REQ_LOAD, 8'($urandom), 8'($urandom), 8'($urandom),
					7'($urandom), 9'($urandom));
			fill_region(rws, cls);
			for (i = $urandom_range(0, 6); i > 0; i--)
				load_pixel(8'($urandom_range(0, rws - 1)), 8'($urandom_range(0, cls - 1)));
			load_pixel(8'($urandom), 8'($urandom));
			push_req(bhim_pkg::REQ_RUN, 8'($urandom), 8'($urandom), 8'($urandom),
				7'($urandom), 9'($urandom));
			read_some($urandom_range(3, 10), rws, cls);
			if ($urandom_range(0, 2) == 0) begin
				push_req(bhim_pkg::REQ_RUN, 8'd0, 8'd0, 8'd0, 7'd0, 9'd0);
				read_some(4, rws, cls);
			end
			rd = $urandom_range(0, 3);
			if (rd == 0)
				drain();
			else
				drain();
		end

		repeat (20) @(posedge clk);
		if (mismatches == 0 && expected_responses.size() == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule

// ===== binary_hex_iterative_modification_unit.f =====
+incdir+src
src/bhim_pkg.sv
src/bhim_match.sv
src/binary_hex_iterative_modification_unit.sv
dv/tb.sv
